// ===== rtl/core/pad_turbo_stick_macro_unit_assert.svh =====
// Assertion macros shared by the pad turbo and stick macro RTL.
`ifndef PAD_TURBO_STICK_MACRO_UNIT_ASSERT_SVH
`define PAD_TURBO_STICK_MACRO_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define PTSM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define PTSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/ptsm_pkg.sv =====
// Types and constants shared by the pad turbo and stick macro modules.
package ptsm_pkg;

    localparam int AXIS_NUM = 4;

    // Button codes as seen in the pressed (active-high) vector.
    localparam logic [15:0] BTN_START = 16'h0008;
    localparam logic [15:0] BTN_UP    = 16'h0010;
    localparam logic [15:0] BTN_RIGHT = 16'h0020;
    localparam logic [15:0] BTN_DOWN  = 16'h0040;
    localparam logic [15:0] BTN_LEFT  = 16'h0080;

    localparam logic [15:0] ALL_RELEASED = 16'hFFFF;

    // Inversion bits per axis.
    localparam logic [3:0] INV_LX = 4'b0001;
    localparam logic [3:0] INV_LY = 4'b0010;
    localparam logic [3:0] INV_RX = 4'b0100;
    localparam logic [3:0] INV_RY = 4'b1000;

    localparam logic [7:0]         CENTER   = 8'd128;
    localparam logic [7:0]         NEAR_CTR = 8'd127;
    localparam logic signed [13:0] SLOW_NUM = 14'sd23;
    localparam logic signed [13:0] SLOW_RND = 14'sd31;
    localparam logic [2:0]         HP_BASE  = 3'd2;

    typedef enum logic [3:0] {
        CFG_LEFT_BUTTON  = 4'd0,
        CFG_LEFT_ENABLE  = 4'd1,
        CFG_LEFT_TOGGLE  = 4'd2,
        CFG_RIGHT_BUTTON = 4'd3,
        CFG_RIGHT_ENABLE = 4'd4,
        CFG_RIGHT_TOGGLE = 4'd5,
        CFG_INVERT_INIT  = 4'd6,
        CFG_TURBO_EXTRA  = 4'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SLOW_HOLD = 2'd0,
        SLOW_OFF  = 2'd2,
        SLOW_ON   = 2'd3
    } t_slow_mode;

    typedef struct packed {
        logic       en;
        t_cfg_idx   idx;
        logic [3:0] data;
    } t_cfg_wr;

    // Per-report result of the control unit, consumed by the lanes and merge stage.
    typedef struct packed {
        logic [15:0] buttons_out_n;
        logic [11:0] clear;
        logic        action;
        logic        slow_left;
        logic        slow_right;
        logic [3:0]  invert;
    } t_ctrl_res;

endpackage

// ===== rtl/core/ptsm_ctrl.sv =====
// Control unit: combo decoding, turbo mask and timer, slowdown and inversion state.
module ptsm_ctrl import ptsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_take,
    input  logic [15:0] i_buttons_n,
    input  logic [7:0]  i_special,
    output t_ctrl_res   o_res
);

    // Configuration registers.
    logic [3:0] r_l_btn, r_r_btn, r_inv_init;
    logic       r_l_en, r_l_tog, r_r_en, r_r_tog;
    logic [1:0] r_extra;

    // Running state.
    logic        r_idle;
    logic [15:0] r_prev_p;
    logic [7:0]  r_prev_s;
    t_slow_mode  r_lmode, r_rmode;
    logic [3:0]  r_inv;
    logic        r_tw;
    logic [15:0] r_mask;
    logic [3:0]  r_cnt;
    logic [2:0]  r_hp;

    t_slow_mode  cur_lmode, cur_rmode, n_lmode, n_rmode;
    logic [3:0]  cur_inv, n_inv;
    logic [2:0]  cur_hp;
    logic [15:0] pressed, p2, n_prev_p, n_mask, bn;
    logic [7:0]  n_prev_s;
    logic        n_tw, blank, action, l_hit, r_hit, released;
    logic [3:0]  cnt_inc, n_cnt;
    logic [20:0] w_macro;

    function automatic t_slow_mode load_mode(input logic en, input logic tog);
        return (en && tog) ? SLOW_OFF : SLOW_HOLD;
    endfunction

    function automatic t_slow_mode flip_mode(input t_slow_mode m);
        t_slow_mode r;
        case (m)
            SLOW_OFF: r = SLOW_ON;
            SLOW_ON:  r = SLOW_OFF;
            default:  r = m;
        endcase
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_btn    <= '0;
            r_l_en     <= 1'b0;
            r_l_tog    <= 1'b0;
            r_r_btn    <= '0;
            r_r_en     <= 1'b0;
            r_r_tog    <= 1'b0;
            r_inv_init <= '0;
            r_extra    <= '0;
        end else if (i_cfg.en) begin
            case (i_cfg.idx)
                CFG_LEFT_BUTTON:  r_l_btn    <= i_cfg.data;
                CFG_LEFT_ENABLE:  r_l_en     <= i_cfg.data[0];
                CFG_LEFT_TOGGLE:  r_l_tog    <= i_cfg.data[0];
                CFG_RIGHT_BUTTON: r_r_btn    <= i_cfg.data;
                CFG_RIGHT_ENABLE: r_r_en     <= i_cfg.data[0];
                CFG_RIGHT_TOGGLE: r_r_tog    <= i_cfg.data[0];
                CFG_INVERT_INIT:  r_inv_init <= i_cfg.data;
                CFG_TURBO_EXTRA:  r_extra    <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // The first transaction after reset works from freshly loaded settings.
        cur_lmode = r_idle ? load_mode(r_l_en, r_l_tog) : r_lmode;
        cur_rmode = r_idle ? load_mode(r_r_en, r_r_tog) : r_rmode;
        cur_inv   = r_idle ? r_inv_init : r_inv;
        cur_hp    = r_idle ? ({1'b0, r_extra} + HP_BASE) : r_hp;

        pressed = ~i_buttons_n;
        l_hit   = r_l_en && pressed[r_l_btn] && !r_prev_p[r_l_btn];
        r_hit   = r_r_en && pressed[r_r_btn] && !r_prev_p[r_r_btn];

        n_prev_p = r_prev_p;
        n_prev_s = r_prev_s;
        n_lmode  = cur_lmode;
        n_rmode  = cur_rmode;
        n_inv    = cur_inv;
        n_tw     = r_tw;
        n_mask   = r_mask;
        blank    = 1'b0;
        action   = 1'b0;

        if (i_special == 8'd0) begin
            if (r_tw && (r_prev_p != pressed) && (pressed != 16'd0)) begin
                blank  = 1'b1;
                n_mask = r_mask ^ pressed;
                n_tw   = 1'b0;
                action = 1'b1;
            end
            if (l_hit) begin
                n_lmode = flip_mode(cur_lmode);
            end
            if (r_hit) begin
                n_rmode = flip_mode(cur_rmode);
            end
            n_prev_p = pressed;
            n_prev_s = 8'd0;
        end else if ((r_prev_p == pressed) && (r_prev_s == i_special)) begin
            blank = 1'b1;
        end else begin
            blank    = 1'b1;
            n_prev_p = pressed;
            n_prev_s = i_special;
            case (pressed)
                BTN_UP: begin
                    n_inv  = cur_inv ^ INV_LY;
                    action = 1'b1;
                end
                BTN_LEFT: begin
                    n_inv  = cur_inv ^ INV_LX;
                    action = 1'b1;
                end
                BTN_DOWN: begin
                    n_inv  = cur_inv ^ INV_RY;
                    action = 1'b1;
                end
                BTN_RIGHT: begin
                    n_inv  = cur_inv ^ INV_RX;
                    action = 1'b1;
                end
                BTN_START: begin
                    n_tw   = ~r_tw;
                    action = 1'b1;
                end
                default: ;
            endcase
        end

        // Hold-mode slowdown sees the buttons after blanking.
        p2 = blank ? 16'd0 : pressed;
        o_res.slow_left  = (n_lmode == SLOW_HOLD) ? (r_l_en && p2[r_l_btn])
                                                  : (n_lmode == SLOW_ON);
        o_res.slow_right = (n_rmode == SLOW_HOLD) ? (r_r_en && p2[r_r_btn])
                                                  : (n_rmode == SLOW_ON);
        o_res.invert = n_inv;
        o_res.action = action;

        cnt_inc  = r_cnt + 4'd1;
        n_cnt    = (cnt_inc >= {cur_hp, 1'b0}) ? 4'd0 : cnt_inc;
        released = (n_cnt < {1'b0, cur_hp});

        bn = blank ? ALL_RELEASED : i_buttons_n;
        o_res.buttons_out_n = released ? (bn | n_mask) : bn;
        o_res.clear         = released ? n_mask[15:4] : 12'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle   <= 1'b1;
            r_prev_p <= '0;
            r_prev_s <= '0;
            r_lmode  <= SLOW_HOLD;
            r_rmode  <= SLOW_HOLD;
            r_inv    <= '0;
            r_tw     <= 1'b0;
            r_mask   <= '0;
            r_cnt    <= '0;
            r_hp     <= HP_BASE;
        end else if (i_take) begin
            r_idle   <= 1'b0;
            r_prev_p <= n_prev_p;
            r_prev_s <= n_prev_s;
            r_lmode  <= n_lmode;
            r_rmode  <= n_rmode;
            r_inv    <= n_inv;
            r_tw     <= n_tw;
            r_mask   <= n_mask;
            r_cnt    <= n_cnt;
            r_hp     <= cur_hp;
        end
    end

    // Settings that a combo can change, gathered for the action check.
    assign w_macro = {r_tw, r_inv, r_mask};

`include "pad_turbo_stick_macro_unit_assert.svh"

    `PTSM_ASSERT_IMPL(a_turbo_count_range, !r_idle, r_cnt < {r_hp, 1'b0})
    `PTSM_ASSERT_NEXT(a_action_changes, i_take && !r_idle && o_res.action, w_macro != $past(w_macro))
    `PTSM_ASSERT_NEXT(a_toggle_mode_kept, !r_idle && (r_lmode != SLOW_HOLD), r_lmode != SLOW_HOLD)

endmodule

// ===== rtl/core/ptsm_lane.sv =====
// One stick axis lane: optional inversion, then optional 23/32 slowdown about centre.
module ptsm_lane import ptsm_pkg::*; (
    input  logic [7:0] i_value,
    input  logic       i_invert,
    input  logic       i_slow,
    output logic [7:0] o_value
);

    logic [7:0]         v;
    logic signed [8:0]  off;
    logic signed [13:0] prod, adj;

    always_comb begin
        // Both centre codes pass through inversion unchanged.
        if (i_invert && (i_value != NEAR_CTR) && (i_value != CENTER)) begin
            v = ~i_value;
        end else begin
            v = i_value;
        end
        off  = $signed({1'b0, v}) - $signed({1'b0, CENTER});
        prod = $signed({{5{off[8]}}, off}) * SLOW_NUM;
        // Bias negative products so the shift truncates toward zero.
        adj  = prod + (prod[13] ? SLOW_RND : 14'sd0);
        o_value = i_slow ? (adj[12:5] + CENTER) : v;
    end

endmodule

// ===== rtl/core/pad_turbo_stick_macro_unit.sv =====
// Top level of the pad turbo and stick macro unit: control, four axis lanes, merge.
//
// One pad report enters per transaction on the s_axis channel and one processed
// report leaves per transaction on the m_axis channel, in the same order.
// Settings are written through the cfg channel (index 0..7, data in bits 3:0,
// other indexes ignored); o_cfg_ready is always high. Write them only while idle.
// A report accepted on s_axis is held in the control register stage, then in the output
// register, from which it leaves on m_axis.
// One report per cycle while the receiver does not stall; all turbo and combo state is
// updated by the control unit as each report is taken.
// The four axes are handled by parallel lanes whose results are merged with
// the button, pressure-clear and action fields in the output register.
// Reset (synchronous, i_rst_n low) empties the pipeline and clears the turbo and
// combo state; the initial inversion, slowdown toggles and turbo half period are
// taken from the settings on the first report after reset.
// When the receiver stalls, the output holds; one more report can still enter the
// control stage, after which s_axis_tready drops until the output drains.
module pad_turbo_stick_macro_unit import ptsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] buttons_n, [23:16] special, [31:24] lx_in, [39:32] ly_in,
    // [47:40] rx_in, [55:48] ry_in
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] buttons_out_n, [23:16] lx_out, [31:24] ly_out, [39:32] rx_out,
    // [47:40] ry_out, [59:48] pressure_clear, [60] action, [63:61] zero
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    t_cfg_wr     w_cfg;
    t_ctrl_res   w_res;
    logic        w_take, w_en_a, w_en_b;

    logic        r_a_valid;
    t_ctrl_res   r_a_res;
    logic [7:0]  r_a_axis [AXIS_NUM];
    logic [7:0]  w_lane_out [AXIS_NUM];

    logic        r_b_valid;
    logic [63:0] r_b_data;
    logic [63:0] n_b_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.en    = i_cfg_valid;
    assign w_cfg.idx   = t_cfg_idx'(i_cfg_index);
    assign w_cfg.data  = i_cfg_data;

    assign w_en_b        = !r_b_valid || m_axis_tready;
    assign w_en_a        = !r_a_valid || w_en_b;
    assign s_axis_tready = w_en_a;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    ptsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_take      (w_take),
        .i_buttons_n (s_axis_tdata[15:0]),
        .i_special   (s_axis_tdata[23:16]),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_res     <= w_res;
            r_a_axis[0] <= s_axis_tdata[31:24];
            r_a_axis[1] <= s_axis_tdata[39:32];
            r_a_axis[2] <= s_axis_tdata[47:40];
            r_a_axis[3] <= s_axis_tdata[55:48];
        end
    end

    for (genvar g = 0; g < AXIS_NUM; g++) begin : g_lane
        ptsm_lane u_lane (
            .i_value  (r_a_axis[g]),
            .i_invert (r_a_res.invert[g]),
            .i_slow   ((g < 2) ? r_a_res.slow_left : r_a_res.slow_right),
            .o_value  (w_lane_out[g])
        );
    end

    // Merge the lane results with the control fields.
    always_comb begin
        n_b_data = {3'd0, r_a_res.action, r_a_res.clear,
                    w_lane_out[3], w_lane_out[2], w_lane_out[1], w_lane_out[0],
                    r_a_res.buttons_out_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = r_b_data;

`include "pad_turbo_stick_macro_unit_assert.svh"

    `PTSM_ASSERT_NEXT(a_take_fills_stage, w_take, r_a_valid)
    `PTSM_ASSERT_NEXT(a_stage_moves_on, r_a_valid && !r_b_valid, r_b_valid)
    `PTSM_ASSERT_IMPL(a_ready_when_empty, !r_a_valid, s_axis_tready)

endmodule
